### rtl/vlan_tag_strip_insert_unit_assert.svh
// ----------------------------------------------------------------------------
// vlan tag strip / insert assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef VLAN_TAG_STRIP_INSERT_UNIT_ASSERT_SVH
`define VLAN_TAG_STRIP_INSERT_UNIT_ASSERT_SVH

// same-cycle implication
`define VTSI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtsi same-cycle check failed");

// next-cycle implication
`define VTSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtsi next-cycle check failed");

`endif

### rtl/vtsi_pkg.sv
// ----------------------------------------------------------------------------
// vtsi_pkg
// shared types and constants of the vlan tag strip / insert unit
// ----------------------------------------------------------------------------
package vtsi_pkg;

    // command codes
    localparam logic CMD_STRIP  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // tag protocol identifier bytes
    localparam logic [7:0] TPID_HI = 8'h81;
    localparam logic [7:0] TPID_LO = 8'h00;

    // byte positions within a frame
    localparam logic [4:0] TPID_LO_POS    = 5'd13;  // second tpid byte
    localparam logic [4:0] INS_PASS_POS   = 5'd14;  // insert: pass-through from here
    localparam logic [4:0] INNER_TYPE_POS = 5'd16;  // strip: first byte after tag
    localparam logic [4:0] STRIP_TAIL_POS = 5'd17;  // strip: decision byte
    localparam logic [4:0] POS_SAT        = 5'd18;  // position counter saturation

    // header hold buffer
    localparam int         HOLD_DEPTH    = 14;
    localparam int         HOLD_IDX_W    = $clog2(HOLD_DEPTH);
    localparam logic [HOLD_IDX_W-1:0] HOLD_TYPE_IDX = HOLD_IDX_W'(12);

    // header burst lengths
    localparam logic [4:0] STRIP_BURST_LEN  = 5'd14;
    localparam logic [4:0] INSERT_BURST_LEN = 5'd18;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_NOT_TAGGED     = 2'd1,
        ST_TOO_SHORT      = 2'd2,
        ST_ALREADY_TAGGED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_SINGLE,
        ACT_BURST
    } act_kind_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        command;
        logic [11:0] tag_vlan_id;
        logic [2:0]  tag_priority;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        status_t    status;
    } out_item_t;

    // what one input item causes on the result side
    typedef struct packed {
        act_kind_t kind;
        logic      mode;
        out_item_t item;  // single result, or burst tail
    } core_act_t;

    // header data read by the burst sequencer
    typedef struct packed {
        logic [7:0]  hold_byte;
        logic [15:0] tci;
    } burst_src_t;

endpackage

### rtl/vlan_tag_strip_insert_unit.sv
// ----------------------------------------------------------------------------
// vlan_tag_strip_insert_unit
// 802.1q vlan tag strip / insert on a byte-wide ethernet frame stream
// ----------------------------------------------------------------------------
// usage:
//   in channel  (in_valid / in_ready / in_item) carries one frame byte per item
//   with its last flag; command, vid and pcp are sampled on a frame's first byte.
//   out channel (out_valid / out_ready / out_item) carries rewritten bytes, or
//   a single error item (zero byte, last set, nonzero status) for a bad frame.
// path: an item enters the input register at its accepting edge, and its
//   result enters the result register at the edge where the core takes it,
//   from where it is offered on the out channel.
// throughput: 1 item per cycle for pass-through bytes while out_ready is high.
//   header bytes are held and give no result; the decision byte releases a
//   header burst of 14 (strip) or 18 (insert) results, one per cycle while
//   out_ready is high, during which no new item reaches the core.
// stall: when out_ready is low the result holds; the input register still
//   takes one more item, then in_ready drops until results drain.
// reset: clears the frame position, discard flag and both valid flags; the
//   next item accepted is the first byte of a frame.
// ----------------------------------------------------------------------------
module vlan_tag_strip_insert_unit
    import vtsi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic                  take;
    logic                  core_ready;
    in_item_t              item;
    core_act_t             act;
    burst_src_t            src;
    logic [HOLD_IDX_W-1:0] rd_idx;

    // input register
    vtsi_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .core_ready (core_ready),
        .take       (take),
        .item       (item)
    );

    // frame state and decision
    vtsi_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .act    (act),
        .rd_idx (rd_idx),
        .src    (src)
    );

    // result register and burst sequencer
    vtsi_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .act        (act),
        .src        (src),
        .rd_idx     (rd_idx),
        .core_ready (core_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

### rtl/vtsi_in_stage.sv
// ----------------------------------------------------------------------------
// vtsi_in_stage
// input register of the unit, handing one item per cycle to the frame core while the core is ready
// ----------------------------------------------------------------------------
module vtsi_in_stage
    import vtsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     core_ready,
    output logic     take,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // core consumes the held item when the result side has room and no burst is being sent
    assign take     = valid_reg && core_ready;
    assign in_ready = !valid_reg || take;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### rtl/vtsi_core.sv
// ----------------------------------------------------------------------------
// vtsi_core
// per-frame state, header hold buffer and the strip / insert decision
// ----------------------------------------------------------------------------
`include "vlan_tag_strip_insert_unit_assert.svh"

module vtsi_core
    import vtsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  in_item_t              item,
    output core_act_t             act,
    input  logic [HOLD_IDX_W-1:0] rd_idx,
    output burst_src_t            src
);

    logic [4:0]            pos_reg;
    logic [4:0]            pos_next;
    logic                  discard_reg;
    logic                  discard_next;
    logic                  mode_reg;
    logic [11:0]           vid_reg;
    logic [2:0]            pcp_reg;
    logic [7:0]            hold_reg [HOLD_DEPTH];

    logic                  first;
    logic                  mode;
    logic                  tpid_hit;
    logic                  fail;
    status_t               fail_st;
    logic                  hold_we;
    logic [HOLD_IDX_W-1:0] hold_widx;
    logic                  burst_at_decision;

    // header read port for the burst sequencer
    assign src.hold_byte = hold_reg[rd_idx];
    assign src.tci       = {pcp_reg, 1'b0, vid_reg};

    assign first    = (pos_reg == 5'd0);
    assign mode     = first ? item.command : mode_reg;
    assign tpid_hit = (hold_reg[HOLD_TYPE_IDX] == TPID_HI) && (item.data_byte == TPID_LO);

    // frame decision for the current item
    always_comb
    begin
        act.kind          = ACT_NONE;
        act.mode          = mode;
        act.item.out_byte = item.data_byte;
        act.item.out_last = item.last_byte;
        act.item.status   = ST_OK;
        fail              = 1'b0;
        fail_st           = ST_OK;
        hold_we           = 1'b0;
        hold_widx         = pos_reg[HOLD_IDX_W-1:0];

        if (!discard_reg)
        begin
            if (mode == CMD_STRIP)
            begin
                if (pos_reg >= POS_SAT)
                begin
                    act.kind = ACT_SINGLE;
                end
                else if (pos_reg < TPID_LO_POS)
                begin
                    hold_we = 1'b1;
                    if (item.last_byte)
                    begin
                        fail    = 1'b1;
                        fail_st = ST_NOT_TAGGED;
                    end
                end
                else if (pos_reg == TPID_LO_POS)
                begin
                    if (!tpid_hit)
                    begin
                        fail    = 1'b1;
                        fail_st = ST_NOT_TAGGED;
                    end
                    else if (item.last_byte)
                    begin
                        fail    = 1'b1;
                        fail_st = ST_TOO_SHORT;
                    end
                end
                else if (pos_reg < STRIP_TAIL_POS)
                begin
                    // first byte after the tag replaces the tpid in the header
                    if (pos_reg == INNER_TYPE_POS)
                    begin
                        hold_we   = 1'b1;
                        hold_widx = HOLD_TYPE_IDX;
                    end
                    if (item.last_byte)
                    begin
                        fail    = 1'b1;
                        fail_st = ST_TOO_SHORT;
                    end
                end
                else
                begin
                    act.kind = ACT_BURST;
                end
            end
            else
            begin
                if (pos_reg >= INS_PASS_POS)
                begin
                    act.kind = ACT_SINGLE;
                end
                else if (pos_reg < TPID_LO_POS)
                begin
                    hold_we = 1'b1;
                    if (item.last_byte)
                    begin
                        fail    = 1'b1;
                        fail_st = ST_TOO_SHORT;
                    end
                end
                else if (tpid_hit)
                begin
                    fail    = 1'b1;
                    fail_st = ST_ALREADY_TAGGED;
                end
                else
                begin
                    act.kind = ACT_BURST;
                end
            end
        end

        // error result replaces everything else
        if (fail)
        begin
            act.kind          = ACT_SINGLE;
            act.item.out_byte = 8'h00;
            act.item.out_last = 1'b1;
            act.item.status   = fail_st;
        end
    end

    // position and discard update
    always_comb
    begin
        pos_next     = pos_reg;
        discard_next = discard_reg;
        if (discard_reg || fail)
        begin
            if (item.last_byte)
            begin
                pos_next     = 5'd0;
                discard_next = 1'b0;
            end
            else
            begin
                discard_next = 1'b1;
            end
        end
        else if (item.last_byte)
        begin
            pos_next = 5'd0;
        end
        else if (pos_reg < POS_SAT)
        begin
            pos_next = pos_reg + 5'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 5'd0;
            discard_reg <= 1'b0;
            mode_reg    <= CMD_STRIP;
            vid_reg     <= 12'd0;
            pcp_reg     <= 3'd0;
        end
        else if (take)
        begin
            pos_reg     <= pos_next;
            discard_reg <= discard_next;
            if (!discard_reg && first)
            begin
                mode_reg <= item.command;
                vid_reg  <= item.tag_vlan_id;
                pcp_reg  <= item.tag_priority;
            end
        end
    end

    // header hold buffer
    always_ff @(posedge clk)
    begin
        if (take && hold_we)
        begin
            hold_reg[hold_widx] <= item.data_byte;
        end
    end

    // decision byte of the current mode
    assign burst_at_decision = ((pos_reg == STRIP_TAIL_POS) && (act.mode == CMD_STRIP))
                               || ((pos_reg == TPID_LO_POS) && (act.mode == CMD_INSERT));

    // the discard flag is only ever set with the position at the second tpid byte
    `VTSI_ASSERT_SAME(a_discard_pos, discard_reg, pos_reg == TPID_LO_POS)
    // bursts start only at the decision byte of their mode
    `VTSI_ASSERT_SAME(a_burst_pos, take && (act.kind == ACT_BURST), burst_at_decision)

endmodule

### rtl/vtsi_out_stage.sv
// ----------------------------------------------------------------------------
// vtsi_out_stage
// result register and header burst sequencer
// ----------------------------------------------------------------------------
`include "vlan_tag_strip_insert_unit_assert.svh"

module vtsi_out_stage
    import vtsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  core_act_t             act,
    input  burst_src_t            src,
    output logic [HOLD_IDX_W-1:0] rd_idx,
    output logic                  core_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item
);

    // insert burst positions
    localparam logic [4:0] K_TPID_HI  = 5'd12;
    localparam logic [4:0] K_TPID_LO  = 5'd13;
    localparam logic [4:0] K_TCI_HI   = 5'd14;
    localparam logic [4:0] K_TCI_LO   = 5'd15;
    localparam logic [4:0] K_INS_TYPE = 5'd16;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      active_reg;
    logic      active_next;
    logic [4:0] idx_reg;
    logic [4:0] idx_next;
    logic      bmode_reg;
    logic      bmode_next;
    out_item_t tail_reg;
    out_item_t tail_next;

    logic      out_free;
    logic [4:0] k;
    logic      mode_sel;
    out_item_t tail_sel;
    logic [4:0] burst_len_m1;
    out_item_t seq;
    logic      tail_due;
    logic      tail_loaded;

    assign out_free   = !out_valid_reg || out_ready;
    assign core_ready = out_free && !active_reg;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    // burst position being produced
    assign k            = active_reg ? idx_reg : 5'd0;
    assign mode_sel     = active_reg ? bmode_reg : act.mode;
    assign tail_sel     = active_reg ? tail_reg : act.item;
    assign burst_len_m1 = (mode_sel == CMD_INSERT) ? (INSERT_BURST_LEN - 5'd1)
                                                   : (STRIP_BURST_LEN - 5'd1);

    // burst item at position k
    always_comb
    begin
        rd_idx = k[HOLD_IDX_W-1:0];
        if ((mode_sel == CMD_INSERT) && (k == K_INS_TYPE))
        begin
            rd_idx = HOLD_TYPE_IDX;
        end

        seq.out_byte = src.hold_byte;
        seq.out_last = 1'b0;
        seq.status   = ST_OK;

        if (k == burst_len_m1)
        begin
            seq = tail_sel;
        end
        else if (mode_sel == CMD_INSERT)
        begin
            case (k)
                K_TPID_HI: seq.out_byte = TPID_HI;
                K_TPID_LO: seq.out_byte = TPID_LO;
                K_TCI_HI:  seq.out_byte = src.tci[15:8];
                K_TCI_LO:  seq.out_byte = src.tci[7:0];
                default:   seq.out_byte = src.hold_byte;
            endcase
        end
    end

    // result register loading
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        bmode_next     = bmode_reg;
        tail_next      = tail_reg;

        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (active_reg)
            begin
                out_item_next  = seq;
                out_valid_next = 1'b1;
                idx_next       = idx_reg + 5'd1;
                if (idx_reg == burst_len_m1)
                begin
                    active_next = 1'b0;
                end
            end
            else if (take && (act.kind == ACT_SINGLE))
            begin
                out_item_next  = act.item;
                out_valid_next = 1'b1;
            end
            else if (take && (act.kind == ACT_BURST))
            begin
                out_item_next  = seq;
                out_valid_next = 1'b1;
                idx_next       = 5'd1;
                active_next    = 1'b1;
                bmode_next     = act.mode;
                tail_next      = act.item;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            idx_reg       <= 5'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        bmode_reg    <= bmode_next;
        tail_reg     <= tail_next;
    end

    // last burst position and what the result register holds after it
    assign tail_due    = active_reg && out_free && (idx_reg == burst_len_m1);
    assign tail_loaded = out_valid_reg && !active_reg && (out_item_reg == tail_reg);

    // burst index stays inside the burst of the latched mode
    `VTSI_ASSERT_SAME(a_idx_range, active_reg, (idx_reg != 5'd0) && (idx_reg <= burst_len_m1))
    // no new item reaches the core while a burst is being sent
    `VTSI_ASSERT_SAME(a_no_take_in_burst, active_reg, !take)
    // the final burst position carries the tail and ends the burst
    `VTSI_ASSERT_NEXT(a_burst_tail, tail_due, tail_loaded)

endmodule
